### rtl/core/rule_expression_tokenizer_assert.svh
// Assertion macros shared by the tokenizer checker.
// Depends on nothing; included by the checker file only.
`ifndef RULE_EXPRESSION_TOKENIZER_ASSERT_SVH
`define RULE_EXPRESSION_TOKENIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define RET_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/core/ret_pkg.sv
// Shared types and constants for the rule expression tokenizer.
// No dependencies; imported by every tokenizer module.
package ret_pkg;

  localparam int unsigned PosWidthDefault = 16;
  localparam int unsigned QueueDepth      = 4;

  // Token kinds.
  localparam logic [4:0] K_NUM   = 5'd0;
  localparam logic [4:0] K_STR   = 5'd1;
  localparam logic [4:0] K_BOOL  = 5'd2;
  localparam logic [4:0] K_ID    = 5'd3;
  localparam logic [4:0] K_ARROW = 5'd4;
  localparam logic [4:0] K_DOT   = 5'd5;
  localparam logic [4:0] K_PLUS  = 5'd6;
  localparam logic [4:0] K_MINUS = 5'd7;
  localparam logic [4:0] K_STAR  = 5'd8;
  localparam logic [4:0] K_SLASH = 5'd9;
  localparam logic [4:0] K_EQ    = 5'd10;
  localparam logic [4:0] K_NEQ   = 5'd11;
  localparam logic [4:0] K_LT    = 5'd12;
  localparam logic [4:0] K_LE    = 5'd13;
  localparam logic [4:0] K_GT    = 5'd14;
  localparam logic [4:0] K_GE    = 5'd15;
  localparam logic [4:0] K_AND   = 5'd16;
  localparam logic [4:0] K_OR    = 5'd17;
  localparam logic [4:0] K_NOT   = 5'd18;
  localparam logic [4:0] K_IN    = 5'd19;
  localparam logic [4:0] K_LP    = 5'd20;
  localparam logic [4:0] K_RP    = 5'd21;
  localparam logic [4:0] K_LB    = 5'd22;
  localparam logic [4:0] K_RB    = 5'd23;
  localparam logic [4:0] K_COMMA = 5'd24;
  localparam logic [4:0] K_END   = 5'd25;

  // Error codes.
  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_CHAR  = 2'd1;
  localparam logic [1:0] E_UNTRM = 2'd2;
  localparam logic [1:0] E_LONG  = 2'd3;

  // Pending operator codes.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_GT   = 3'd1;
  localparam logic [2:0] OP_LT   = 3'd2;
  localparam logic [2:0] OP_BANG = 3'd3;
  localparam logic [2:0] OP_EQ   = 3'd4;
  localparam logic [2:0] OP_DASH = 3'd5;

  // Keyword tracker codes: table index, none, all.
  localparam logic [3:0] KW_TRUE  = 4'd0;
  localparam logic [3:0] KW_FALSE = 4'd1;
  localparam logic [3:0] KW_AND   = 4'd2;
  localparam logic [3:0] KW_OR    = 4'd3;
  localparam logic [3:0] KW_NOT   = 4'd4;
  localparam logic [3:0] KW_IN    = 4'd5;
  localparam logic [3:0] KW_NONE  = 4'd14;
  localparam logic [3:0] KW_ALL   = 4'd15;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [1:0]  error_code;
    logic [15:0] error_position;
    logic        last_in_run;
  } out_item_t;

  // Up to three results caused by one byte.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
    out_item_t  r2;
  } run_t;

  // Keyword character at offset, or 0 past its end.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] off);
    logic [39:0] s;
    begin
      case (k)
        KW_TRUE:  s = {"true", 8'h00};
        KW_FALSE: s = "false";
        KW_AND:   s = {"AND", 16'h0};
        KW_OR:    s = {"OR", 24'h0};
        KW_NOT:   s = {"NOT", 16'h0};
        KW_IN:    s = {"IN", 24'h0};
        default:  s = '0;
      endcase
      case (off)
        3'd0:    kw_char = s[39:32];
        3'd1:    kw_char = s[31:24];
        3'd2:    kw_char = s[23:16];
        3'd3:    kw_char = s[15:8];
        3'd4:    kw_char = s[7:0];
        default: kw_char = 8'h00;
      endcase
    end
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    case (k)
      KW_TRUE:  kw_len = 3'd4;
      KW_FALSE: kw_len = 3'd5;
      KW_AND:   kw_len = 3'd3;
      KW_OR:    kw_len = 3'd2;
      KW_NOT:   kw_len = 3'd3;
      KW_IN:    kw_len = 3'd2;
      default:  kw_len = 3'd0;
    endcase
  endfunction

  function automatic logic [4:0] kw_kind(input logic [3:0] k);
    case (k)
      KW_TRUE:  kw_kind = K_BOOL;
      KW_FALSE: kw_kind = K_BOOL;
      KW_AND:   kw_kind = K_AND;
      KW_OR:    kw_kind = K_OR;
      KW_NOT:   kw_kind = K_NOT;
      KW_IN:    kw_kind = K_IN;
      default:  kw_kind = K_ID;
    endcase
  endfunction

endpackage

### rtl/core/ret_front.sv
// Tokenizer front: accepts bytes, runs the scanner state and forms result runs.
// Depends on ret_pkg.
module ret_front #(
  parameter int unsigned POS_WIDTH = ret_pkg::PosWidthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ret_pkg::in_item_t in_data,
  output logic              run_valid,
  input  logic              run_full,
  output ret_pkg::run_t     run_data
);
  import ret_pkg::*;

  typedef enum logic [6:0] {
    M_IDLE   = 7'b0000001,
    M_OP     = 7'b0000010,
    M_DOT    = 7'b0000100,
    M_INT    = 7'b0001000,
    M_FRAC   = 7'b0010000,
    M_IDENT  = 7'b0100000,
    M_STRING = 7'b1000000
  } mode_t;

  localparam logic [POS_WIDTH-1:0] PosMax = {POS_WIDTH{1'b1}};

  mode_t                mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] beg_r, beg_nxt;
  logic [2:0]           op_r, op_nxt;
  logic [3:0]           kw_r, kw_nxt;
  logic                 dq_r, dq_nxt;
  logic                 dotp_r, dotp_nxt;
  logic                 err_r, err_nxt;

  logic       acc;
  logic [7:0] c;
  logic       eos;
  logic       dig, alp, idc, spc;
  run_t       run;

  assign in_stall  = run_full;
  assign acc       = in_valid && !run_full;
  assign c         = in_data.char_code;
  assign eos       = in_data.end_of_source;
  assign dig       = (c >= "0") && (c <= "9");
  assign alp       = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  assign idc       = alp || dig || (c == "_");
  assign spc       = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign run_valid = acc && (run.count != 2'd0);
  assign run_data  = run;

  // Step the scanner for one accepted item and collect its results.
  always_comb begin
    logic [POS_WIDTH-1:0] p, tb;
    logic [2:0]           off;
    logic                 consumed;
    out_item_t            it;
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    beg_nxt  = beg_r;
    op_nxt   = op_r;
    kw_nxt   = kw_r;
    dq_nxt   = dq_r;
    dotp_nxt = dotp_r;
    err_nxt  = err_r;
    run      = '0;
    p        = pos_r;
    tb       = beg_r;
    off      = (p - tb > POS_WIDTH'(7)) ? 3'd7 : 3'((p - tb));
    consumed = 1'b0;
    it       = '0;

    if (eos) begin
      if (!err_r) begin
        case (mode_r)
          M_OP: begin
            case (op_r)
              OP_GT:   begin it.token_kind = K_GT; it.token_length = 16'd1; end
              OP_LT:   begin it.token_kind = K_LT; it.token_length = 16'd1; end
              OP_DASH: begin it.token_kind = K_MINUS; it.token_length = 16'd1; end
              default: begin it.error_code = E_CHAR; it.error_position = 16'(tb); end
            endcase
            if (it.error_code == E_NONE) it.token_start = 16'(tb);
            run.r0 = it; run.count = 2'd1;
          end
          M_DOT: begin
            it.token_kind = K_DOT; it.token_start = 16'(tb); it.token_length = 16'd1;
            run.r0 = it; run.count = 2'd1;
          end
          M_INT: begin
            if (dotp_r) begin
              it.token_kind = K_NUM; it.token_start = 16'(tb);
              it.token_length = 16'(p - 1'b1 - tb);
              run.r0 = it;
              it.token_kind = K_DOT; it.token_start = 16'(p - 1'b1);
              it.token_length = 16'd1;
              run.r1 = it; run.count = 2'd2;
            end else begin
              it.token_kind = K_NUM; it.token_start = 16'(tb);
              it.token_length = 16'(p - tb);
              run.r0 = it; run.count = 2'd1;
            end
          end
          M_FRAC: begin
            it.token_kind = K_NUM; it.token_start = 16'(tb); it.token_length = 16'(p - tb);
            run.r0 = it; run.count = 2'd1;
          end
          M_IDENT: begin
            it.token_kind = (kw_r < 4'd6 && 3'((p - tb)) == kw_len(kw_r) && (p - tb) < 8)
                            ? kw_kind(kw_r) : K_ID;
            it.token_start = 16'(tb); it.token_length = 16'(p - tb);
            run.r0 = it; run.count = 2'd1;
          end
          M_STRING: begin
            it.error_code = E_UNTRM; it.error_position = 16'(tb);
            run.r0 = it; run.count = 2'd1;
          end
          default: ;
        endcase
        if (!(run.count == 2'd1 && run.r0.error_code != E_NONE)) begin
          it = '0;
          it.token_kind = K_END; it.token_start = 16'(p);
          if (run.count == 2'd0) run.r0 = it;
          else if (run.count == 2'd1) run.r1 = it;
          else run.r2 = it;
          run.count = run.count + 2'd1;
        end
      end
      mode_nxt = M_IDLE; pos_nxt = '0; beg_nxt = '0; op_nxt = OP_NONE;
      kw_nxt = KW_ALL; dq_nxt = 1'b0; dotp_nxt = 1'b0; err_nxt = 1'b0;
    end else if (!err_r) begin
      if (p == PosMax) begin
        it.error_code = E_LONG; it.error_position = 16'(p);
        run.r0 = it; run.count = 2'd1;
        err_nxt = 1'b1; mode_nxt = M_IDLE;
      end else begin
        pos_nxt = p + 1'b1;
        // Resolve the pending token against this byte.
        case (mode_r)
          M_OP: begin
            mode_nxt = M_IDLE; op_nxt = OP_NONE; kw_nxt = KW_ALL; dotp_nxt = 1'b0;
            it.token_start = 16'(tb);
            case (op_r)
              OP_GT: begin
                consumed = (c == "=");
                it.token_kind = consumed ? K_GE : K_GT;
              end
              OP_LT: begin
                consumed = (c == "=");
                it.token_kind = consumed ? K_LE : K_LT;
              end
              OP_DASH: begin
                consumed = (c == ">");
                it.token_kind = consumed ? K_ARROW : K_MINUS;
              end
              default: begin
                consumed = 1'b1;
                if (c == "=") begin
                  it.token_kind = (op_r == OP_BANG) ? K_NEQ : K_EQ;
                end else begin
                  it = '0; it.error_code = E_CHAR; it.error_position = 16'(tb);
                  err_nxt = 1'b1;
                end
              end
            endcase
            if (it.error_code == E_NONE) it.token_length = consumed ? 16'd2 : 16'd1;
            run.r0 = it; run.count = 2'd1;
          end
          M_DOT: begin
            if (dig) begin
              consumed = 1'b1; mode_nxt = M_FRAC;
            end else begin
              mode_nxt = M_IDLE; op_nxt = OP_NONE; kw_nxt = KW_ALL; dotp_nxt = 1'b0;
              it.token_kind = K_DOT; it.token_start = 16'(tb); it.token_length = 16'd1;
              run.r0 = it; run.count = 2'd1;
            end
          end
          M_INT: begin
            if (dotp_r) begin
              if (dig) begin
                consumed = 1'b1; dotp_nxt = 1'b0; mode_nxt = M_FRAC;
              end else begin
                mode_nxt = M_IDLE; op_nxt = OP_NONE; kw_nxt = KW_ALL; dotp_nxt = 1'b0;
                it.token_kind = K_NUM; it.token_start = 16'(tb);
                it.token_length = 16'(p - 1'b1 - tb);
                run.r0 = it;
                it.token_kind = K_DOT; it.token_start = 16'(p - 1'b1);
                it.token_length = 16'd1;
                run.r1 = it; run.count = 2'd2;
              end
            end else if (dig) begin
              consumed = 1'b1;
            end else if (c == ".") begin
              consumed = 1'b1; dotp_nxt = 1'b1;
            end else begin
              mode_nxt = M_IDLE; op_nxt = OP_NONE; kw_nxt = KW_ALL; dotp_nxt = 1'b0;
              it.token_kind = K_NUM; it.token_start = 16'(tb);
              it.token_length = 16'(p - tb);
              run.r0 = it; run.count = 2'd1;
            end
          end
          M_FRAC: begin
            if (dig) begin
              consumed = 1'b1;
            end else begin
              mode_nxt = M_IDLE; op_nxt = OP_NONE; kw_nxt = KW_ALL; dotp_nxt = 1'b0;
              it.token_kind = K_NUM; it.token_start = 16'(tb);
              it.token_length = 16'(p - tb);
              run.r0 = it; run.count = 2'd1;
            end
          end
          M_IDENT: begin
            if (idc) begin
              consumed = 1'b1;
              if (kw_r < 4'd6) begin
                if ((p - tb) >= 8 || off >= kw_len(kw_r) || kw_char(kw_r, off) != c)
                  kw_nxt = KW_NONE;
              end
            end else begin
              it.token_kind = (kw_r < 4'd6 && (p - tb) < 8 && off == kw_len(kw_r))
                              ? kw_kind(kw_r) : K_ID;
              it.token_start = 16'(tb); it.token_length = 16'(p - tb);
              run.r0 = it; run.count = 2'd1;
              mode_nxt = M_IDLE; op_nxt = OP_NONE; kw_nxt = KW_ALL; dotp_nxt = 1'b0;
            end
          end
          M_STRING: begin
            consumed = 1'b1;
            if (c == (dq_r ? 8'h22 : 8'h27)) begin
              it.token_kind = K_STR; it.token_start = 16'(tb);
              it.token_length = 16'(p - tb - 1'b1);
              run.r0 = it; run.count = 2'd1;
              mode_nxt = M_IDLE; op_nxt = OP_NONE; kw_nxt = KW_ALL; dotp_nxt = 1'b0;
            end
          end
          default: ;
        endcase
        // Start a new token with an unconsumed byte.
        if (!consumed) begin
          it = '0;
          beg_nxt = p;
          it.token_start = 16'(p); it.token_length = 16'd1;
          if (!spc) begin
            case (c)
              ">": begin mode_nxt = M_OP; op_nxt = OP_GT; end
              "<": begin mode_nxt = M_OP; op_nxt = OP_LT; end
              "!": begin mode_nxt = M_OP; op_nxt = OP_BANG; end
              "=": begin mode_nxt = M_OP; op_nxt = OP_EQ; end
              "-": begin mode_nxt = M_OP; op_nxt = OP_DASH; end
              ".": mode_nxt = M_DOT;
              8'h22, 8'h27: begin mode_nxt = M_STRING; dq_nxt = (c == 8'h22); end
              "+", "*", "/", "(", ")", "[", "]", ",": begin
                case (c)
                  "+":     it.token_kind = K_PLUS;
                  "*":     it.token_kind = K_STAR;
                  "/":     it.token_kind = K_SLASH;
                  "(":     it.token_kind = K_LP;
                  ")":     it.token_kind = K_RP;
                  "[":     it.token_kind = K_LB;
                  "]":     it.token_kind = K_RB;
                  default: it.token_kind = K_COMMA;
                endcase
                if (run.count == 2'd0) run.r0 = it;
                else if (run.count == 2'd1) run.r1 = it;
                else run.r2 = it;
                run.count = run.count + 2'd1;
              end
              default: begin
                if (dig) begin
                  mode_nxt = M_INT; dotp_nxt = 1'b0;
                end else if (alp || c == "_") begin
                  mode_nxt = M_IDENT;
                  kw_nxt = KW_NONE;
                  case (c)
                    "t": kw_nxt = KW_TRUE;
                    "f": kw_nxt = KW_FALSE;
                    "A": kw_nxt = KW_AND;
                    "O": kw_nxt = KW_OR;
                    "N": kw_nxt = KW_NOT;
                    "I": kw_nxt = KW_IN;
                    default: ;
                  endcase
                end else begin
                  it = '0; it.error_code = E_CHAR; it.error_position = 16'(p);
                  err_nxt = 1'b1; mode_nxt = M_IDLE;
                  if (run.count == 2'd0) run.r0 = it;
                  else if (run.count == 2'd1) run.r1 = it;
                  else run.r2 = it;
                  run.count = run.count + 2'd1;
                end
              end
            endcase
          end
        end
      end
    end
    // Mark the last result of the run.
    case (run.count)
      2'd1:    run.r0.last_in_run = 1'b1;
      2'd2:    run.r1.last_in_run = 1'b1;
      2'd3:    run.r2.last_in_run = 1'b1;
      default: ;
    endcase
  end

  // Advance the scanner on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pos_r <= '0; beg_r <= '0; op_r <= OP_NONE;
      kw_r <= KW_ALL; dq_r <= 1'b0; dotp_r <= 1'b0; err_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; beg_r <= beg_nxt; op_r <= op_nxt;
      kw_r <= kw_nxt; dq_r <= dq_nxt; dotp_r <= dotp_nxt; err_r <= err_nxt;
    end
  end

endmodule

### rtl/core/ret_queue.sv
// Short run queue between the tokenizer front and back.
// Depends on ret_pkg.
module ret_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          full,
  input  ret_pkg::run_t wr_data,
  output logic          rd_valid,
  input  logic          rd_take,
  output ret_pkg::run_t rd_data
);
  import ret_pkg::*;

  localparam int unsigned AW = $clog2(QueueDepth);

  run_t        mem [QueueDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW+1)'(QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];

  // Store incoming runs.
  always_ff @(posedge clk) begin
    if (wr_valid && !full) mem[wp_r] <= wr_data;
  end

  // Advance pointers and the fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_valid && !full) wp_r <= wp_r + 1'b1;
      if (rd_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_valid && !full) - (AW+1)'(rd_take);
    end
  end

endmodule

### rtl/core/ret_back.sv
// Tokenizer back: unpacks result runs into single results.
// Depends on ret_pkg.
module ret_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               run_valid,
  input  ret_pkg::run_t      run_data,
  output logic               run_take,
  output logic               out_valid,
  input  logic               out_stall,
  output ret_pkg::out_item_t out_data
);
  import ret_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_r;
  logic       load;
  logic       last;
  out_item_t  sel;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load      = run_valid && (!out_valid_r || !out_stall);
  assign last      = (idx_r + 2'd1 == run_data.count);
  assign run_take  = load && last;

  always_comb begin
    case (idx_r)
      2'd0:    sel = run_data.r0;
      2'd1:    sel = run_data.r1;
      default: sel = run_data.r2;
    endcase
  end

  // Hold the output while stalled; step through the run otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0; out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= run_valid;
      if (run_valid) idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= sel;
  end

endmodule

### rtl/core/rule_expression_tokenizer.sv
// Top level of the rule expression tokenizer.
// Depends on ret_pkg, ret_front, ret_queue and ret_back.
//
// Usage: feed one source byte per item on in_* (valid/stall); set
// end_of_source to close the text, which flushes any pending token, emits
// End unless an error ended the text, and returns the scanner to position 0. Tokens and errors leave on
// out_* as one item each; last_in_run marks the final result of a byte.
// Path: the first result of a byte passes through the run queue, then the
// output register. Throughput: one byte per cycle while in_stall is low; a
// byte causing two or three results occupies the output for each of them in
// turn, absorbed by a four-entry run queue. The queue fill sets when
// in_stall rises.
// Reset: rst_n low for one edge clears scanner state, queue and output.
// A stall on out_* holds the current result; bytes keep entering until the
// queue fills, then in_stall is raised.
module rule_expression_tokenizer #(
  parameter int unsigned POS_WIDTH = ret_pkg::PosWidthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ret_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ret_pkg::out_item_t out_data
);
  import ret_pkg::*;

  logic run_valid, run_full, q_valid, q_take;
  run_t run_data, q_data;

  ret_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .run_valid, .run_full, .run_data
  );

  ret_queue u_queue (
    .clk, .rst_n, .wr_valid(run_valid), .full(run_full), .wr_data(run_data),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
  );

  ret_back u_back (
    .clk, .rst_n, .run_valid(q_valid), .run_data(q_data), .run_take(q_take),
    .out_valid, .out_stall, .out_data
  );

endmodule

### rtl/core/ret_checker.sv
// Port-level checker for the rule expression tokenizer, bound to the top.
// Depends on ret_pkg and rule_expression_tokenizer_assert.svh.
`include "rule_expression_tokenizer_assert.svh"
module ret_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ret_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ret_pkg::out_item_t out_data
);
  import ret_pkg::*;

  `RET_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_data), "stalled request changed")
  `RET_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `RET_ASSERT_IMP(a_err_clean, clk, rst_n, out_valid && out_data.error_code != E_NONE, out_data.token_kind == K_NUM && out_data.token_length == 16'd0 && out_data.last_in_run, "error result malformed")
  `RET_ASSERT_IMP(a_kind_range, clk, rst_n, out_valid, out_data.token_kind <= K_END, "token kind out of range")
  `RET_ASSERT_IMP(a_end_last, clk, rst_n, out_valid && out_data.token_kind == K_END && out_data.error_code == E_NONE, out_data.last_in_run && out_data.token_length == 16'd0, "End not last")

endmodule

bind rule_expression_tokenizer ret_checker u_ret_checker (.*);

### bench/tb_rule_expression_tokenizer.sv
// Testbench for the rule expression tokenizer: directed and random source text.
// Depends on ret_pkg and rule_expression_tokenizer; predicts tokens per byte.
module tb_rule_expression_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import ret_pkg::*;

  typedef enum int {SC_IDLE, SC_OP, SC_DOT, SC_INT, SC_FRAC, SC_IDENT, SC_STR} scan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  rule_expression_tokenizer u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Lexer state mirror.
  scan_t lx_mode;
  logic [15:0] lx_pos, lx_begin;
  logic [2:0] lx_op;
  logic [3:0] lx_kw;
  logic lx_dq, lx_dotp, lx_err;

  out_item_t token_q[$];
  int run_n;
  bit failed = 1'b0;
  bit idle_en = 1'b1;
  longint cycles = 0;

  function automatic bit is_dig(int c); return c >= "0" && c <= "9"; endfunction
  function automatic bit is_alp(int c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction
  function automatic bit is_idc(int c); return is_alp(c) || is_dig(c) || c == "_"; endfunction

  // Keyword spelling as a string.
  function automatic string kw_text(logic [3:0] k);
    case (k)
      KW_TRUE: return "true";
      KW_FALSE: return "false";
      KW_AND: return "AND";
      KW_OR: return "OR";
      KW_NOT: return "NOT";
      KW_IN: return "IN";
      default: return "";
    endcase
  endfunction

  function automatic logic [4:0] kw_token(logic [3:0] k);
    case (k)
      KW_TRUE, KW_FALSE: return K_BOOL;
      KW_AND: return K_AND;
      KW_OR: return K_OR;
      KW_NOT: return K_NOT;
      KW_IN: return K_IN;
      default: return K_ID;
    endcase
  endfunction

  function automatic void push_token(logic [4:0] k, logic [15:0] s, logic [15:0] l,
                                     logic [1:0] e, logic [15:0] ep);
    out_item_t r;
    r = '0;
    r.token_kind = k; r.token_start = s; r.token_length = l;
    r.error_code = e; r.error_position = ep;
    if (run_n < 3) begin
      token_q.insert(token_q.size(), r);
      run_n++;
    end
  endfunction

  function automatic void lex_fail(logic [1:0] code, logic [15:0] where);
    push_token(K_NUM, 16'd0, 16'd0, code, where);
    lx_err = 1'b1;
    lx_mode = SC_IDLE;
  endfunction

  function automatic void lex_idle();
    lx_mode = SC_IDLE; lx_op = OP_NONE; lx_kw = KW_ALL; lx_dotp = 1'b0;
  endfunction

  function automatic void lex_reset();
    lex_idle();
    lx_pos = '0; lx_begin = '0; lx_dq = 1'b0; lx_err = 1'b0;
  endfunction

  function automatic void kw_track(int c, int off);
    string t;
    if (lx_kw == KW_ALL) begin
      lx_kw = KW_NONE;
      for (int i = 0; i < 6; i++) begin
        t = kw_text(i[3:0]);
        if (t[0] == c) lx_kw = i[3:0];
      end
    end else if (lx_kw < 6) begin
      t = kw_text(lx_kw);
      if (off >= t.len() || t[off] != c) lx_kw = KW_NONE;
    end
  endfunction

  // Settle the pending token with c (-1 at end); return 1 if c was used.
  function automatic bit lex_settle(int c, logic [15:0] p);
    logic [2:0] op;
    logic [4:0] k;
    string t;
    case (lx_mode)
      SC_OP: begin
        op = lx_op;
        lex_idle();
        if (op == OP_GT) begin
          if (c == "=") begin push_token(K_GE, lx_begin, 16'd2, E_NONE, 16'd0); return 1; end
          push_token(K_GT, lx_begin, 16'd1, E_NONE, 16'd0); return 0;
        end
        if (op == OP_LT) begin
          if (c == "=") begin push_token(K_LE, lx_begin, 16'd2, E_NONE, 16'd0); return 1; end
          push_token(K_LT, lx_begin, 16'd1, E_NONE, 16'd0); return 0;
        end
        if (op == OP_DASH) begin
          if (c == ">") begin
            push_token(K_ARROW, lx_begin, 16'd2, E_NONE, 16'd0); return 1;
          end
          push_token(K_MINUS, lx_begin, 16'd1, E_NONE, 16'd0); return 0;
        end
        if (c == "=") begin
          push_token(op == OP_BANG ? K_NEQ : K_EQ, lx_begin, 16'd2, E_NONE, 16'd0);
          return 1;
        end
        lex_fail(E_CHAR, lx_begin);
        return 1;
      end
      SC_DOT: begin
        if (is_dig(c)) begin lx_mode = SC_FRAC; return 1; end
        lex_idle();
        push_token(K_DOT, lx_begin, 16'd1, E_NONE, 16'd0);
        return 0;
      end
      SC_INT: begin
        if (lx_dotp) begin
          if (is_dig(c)) begin lx_dotp = 0; lx_mode = SC_FRAC; return 1; end
          lex_idle();
          push_token(K_NUM, lx_begin, p - 16'd1 - lx_begin, E_NONE, 16'd0);
          push_token(K_DOT, p - 16'd1, 16'd1, E_NONE, 16'd0);
          return 0;
        end
        if (is_dig(c)) return 1;
        if (c == ".") begin lx_dotp = 1; return 1; end
        lex_idle();
        push_token(K_NUM, lx_begin, p - lx_begin, E_NONE, 16'd0);
        return 0;
      end
      SC_FRAC: begin
        if (is_dig(c)) return 1;
        lex_idle();
        push_token(K_NUM, lx_begin, p - lx_begin, E_NONE, 16'd0);
        return 0;
      end
      SC_IDENT: begin
        if (is_idc(c)) begin kw_track(c, p - lx_begin); return 1; end
        k = K_ID;
        t = kw_text(lx_kw);
        if (lx_kw < 6 && (p - lx_begin) == t.len()) k = kw_token(lx_kw);
        push_token(k, lx_begin, p - lx_begin, E_NONE, 16'd0);
        lex_idle();
        return 0;
      end
      SC_STR: begin
        if (c < 0) begin lex_fail(E_UNTRM, lx_begin); return 1; end
        if (c == (lx_dq ? "\"" : "'")) begin
          push_token(K_STR, lx_begin, p - lx_begin - 16'd1, E_NONE, 16'd0);
          lex_idle();
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic lex_begin(int c, logic [15:0] p);
    lx_begin = p;
    if (c == " " || (c >= 9 && c <= 13)) return;
    case (c)
      ">": begin lx_mode = SC_OP; lx_op = OP_GT; end
      "<": begin lx_mode = SC_OP; lx_op = OP_LT; end
      "!": begin lx_mode = SC_OP; lx_op = OP_BANG; end
      "=": begin lx_mode = SC_OP; lx_op = OP_EQ; end
      "-": begin lx_mode = SC_OP; lx_op = OP_DASH; end
      "+": push_token(K_PLUS, p, 16'd1, E_NONE, 16'd0);
      "*": push_token(K_STAR, p, 16'd1, E_NONE, 16'd0);
      "/": push_token(K_SLASH, p, 16'd1, E_NONE, 16'd0);
      "(": push_token(K_LP, p, 16'd1, E_NONE, 16'd0);
      ")": push_token(K_RP, p, 16'd1, E_NONE, 16'd0);
      "[": push_token(K_LB, p, 16'd1, E_NONE, 16'd0);
      "]": push_token(K_RB, p, 16'd1, E_NONE, 16'd0);
      ",": push_token(K_COMMA, p, 16'd1, E_NONE, 16'd0);
      ".": lx_mode = SC_DOT;
      "\"", "'": begin lx_mode = SC_STR; lx_dq = (c == "\""); end
      default: begin
        if (is_dig(c)) begin
          lx_mode = SC_INT; lx_dotp = 0;
        end else if (is_alp(c) || c == "_") begin
          lx_mode = SC_IDENT; lx_kw = KW_ALL; kw_track(c, 0);
        end else begin
          lex_fail(E_CHAR, p);
        end
      end
    endcase
  endtask

  // Predict the tokens one request produces.
  task automatic lex_byte(in_item_t it);
    int c;
    int first;
    logic [15:0] p;
    bit used;
    c = it.char_code;
    p = lx_pos;
    run_n = 0;
    first = token_q.size();
    if (it.end_of_source) begin
      if (!lx_err) begin
        used = lex_settle(-1, p);
        if (!lx_err) push_token(K_END, p, 16'd0, E_NONE, 16'd0);
      end
      lex_reset();
    end else if (!lx_err) begin
      if (p == 16'hFFFF) begin
        lex_fail(E_LONG, p);
      end else begin
        used = lex_settle(c, p);
        if (!used && !lx_err) lex_begin(c, p);
        lx_pos = p + 16'd1;
      end
    end
    if (token_q.size() > first) token_q[token_q.size() - 1].last_in_run = 1'b1;
  endtask

  // Send one request, predicting at acceptance; valid drops only for idle gaps.
  task automatic send_byte(logic [7:0] ch, bit eos);
    if (idle_en && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (idle_en && $urandom_range(99) < 24);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: ch, end_of_source: eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_byte('{char_code: ch, end_of_source: eos});
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic end_source();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $realtime, out_data);
        failed = 1'b1;
      end else begin
        if (out_data !== token_q[0]) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, token_q[0], out_data);
          failed = 1'b1;
        end
        void'(token_q.pop_front());
      end
    end
    if (cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Random receiver stall.
  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 24);
  end

  // Run with no idling on either side.
  task automatic test_operators();
    idle_en = 1'b0;
    send_text(">=<=!===->> <-+*/()[],.x");
    end_source();
    idle_en = 1'b1;
  endtask

  task automatic test_literals();
    send_text("1.5 7. .5.3'ab'\"c\" true false AND OR NOT IN INX _a");
    end_source();
  endtask

  task automatic test_errors();
    send_text("!x");
    end_source();
    send_text("= ");
    end_source();
    send_text("1#");
    end_source();
    send_text("'op");
    end_source();
    send_byte(8'hFF, 1'b0);
    end_source();
    send_text("x");
    end_source();
  endtask

  task automatic test_random();
    string pieces[] = '{"abc", "true", "IN", "NOT", "12", "3.25", ".7", "'s q'",
                        "\"x\"", ">=", "->", "!=", "==", "<", "(", ")", "[", "]",
                        ",", " ", "\t", "+", "*", "/", "-", "."};
    for (int n = 0; n < 2; n++) begin
      for (int i = 0; i < 6; i++) begin
        if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)), 1'b0);
        else send_text(pieces[$urandom_range(pieces.size() - 1)]);
      end
      end_source();
    end
  endtask

  initial begin
    lex_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_operators();
    test_literals();
    test_errors();
    test_random();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
